[src/rba_pkg.sv]
// Package for the rotating bilinear alpha block: payload words, register
// indexes, sequencer states and the fixed widths shared by all modules.
// No dependencies.
package rba_pkg;

    // Source store geometry. The depth is a power of two so that
    // addresses wrap by truncation.
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Configuration port.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH     = 3'd0,
        CFG_SRC_HEIGHT    = 3'd1,
        CFG_DST_WIDTH     = 3'd2,
        CFG_DST_HEIGHT    = 3'd3,
        CFG_COS           = 3'd4,
        CFG_SIN           = 3'd5,
        CFG_DEFAULT_ALPHA = 3'd6
    } cfg_reg_t;

    // Operation codes carried in the mode field.
    localparam logic MODE_STORE   = 1'b0;
    localparam logic MODE_COMPUTE = 1'b1;

    // Arithmetic widths.
    localparam int WGT_W      = 13;  // tap weight, up to 4096
    localparam int TOT_W      = 15;  // sum of four tap weights
    localparam int SUM_W      = 22;  // sum of alpha times weight
    localparam int QUO_W      = 8;   // quotient bits
    localparam int DIV_CNT_W  = $clog2(QUO_W);
    localparam int MUL_W      = 17;  // shared multiplier operand width
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 28;  // rotation dot product
    localparam int POS_W      = 26;  // Q12 source position
    localparam int COORD_W    = 16;  // integer source coordinate

    localparam logic [WGT_W-1:0] ONE_Q12  = WGT_W'(4096);
    localparam logic [TOT_W-1:0] TOT_MAX  = TOT_W'(16384);

    typedef struct packed {
        logic       mode;
        logic [15:0] pixel_index;
        logic [7:0]  alpha_in;
        logic [8:0]  dst_x;
        logic [8:0]  dst_y;
    } req_t;

    typedef struct packed {
        logic [8:0] out_x;
        logic [8:0] out_y;
        logic [7:0] alpha_out;
        logic       outside;
    } rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_XC,
        ST_YS,
        ST_XS,
        ST_YC,
        ST_YEND,
        ST_CHECK,
        ST_W01,
        ST_W10,
        ST_W11,
        ST_ROW0,
        ST_ROW1,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_MAC3,
        ST_MAC4,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[src/rba_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/rba_div.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on rba_pkg for widths and the status struct.
module rba_div import rba_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [TOT_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [QUO_W-1:0] quotient
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(QUO_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     dvs_reg, dvs_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic                 zero_reg, zero_next;

    // The caller guarantees dividend < divisor * 2^QUO_W, so QUO_W steps
    // with the divisor aligned at the top bit give the whole quotient.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend;
            dvs_next  = SUM_W'(divisor) << (QUO_W - 1);
            quo_next  = '0;
            zero_next = (divisor == '0);
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_next = rem_reg - dvs_reg;
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    // A zero weight total gives an alpha of zero.
    assign quotient  = zero_reg ? '0 : quo_reg;

endmodule

[src/rotate_bilinear_alpha_top.sv]
// Rotating bilinear alpha: a store word is written into the alpha store and the block stays ready.
// A compute word runs the whole sequence when the window touches the source, and skips the
// weights, reads and divide when it lies wholly outside; no new word is taken until its result is loaded.
// Its length is set by the single shared 17x17 multiplier (14 products per pixel, one a cycle)
// and the restoring divider. Reset is asynchronous and active low; it loads the
// register defaults and empties the result slot. The alpha store is not cleared.
module rotate_bilinear_alpha_top import rba_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [8:0]         src_width_reg;
    logic [8:0]         src_height_reg;
    logic [9:0]         dst_width_reg;
    logic [9:0]         dst_height_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic [7:0]         dflt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 9'd256;
            src_height_reg <= 9'd256;
            dst_width_reg  <= 10'd256;
            dst_height_reg <= 10'd256;
            cos_reg        <= 16'sd16384;
            sin_reg        <= 16'sd0;
            dflt_reg       <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:     src_width_reg  <= cfg_data[8:0];
                CFG_SRC_HEIGHT:    src_height_reg <= cfg_data[8:0];
                CFG_DST_WIDTH:     dst_width_reg  <= cfg_data[9:0];
                CFG_DST_HEIGHT:    dst_height_reg <= cfg_data[9:0];
                CFG_COS:           cos_reg        <= cfg_data;
                CFG_SIN:           sin_reg        <= cfg_data;
                CFG_DEFAULT_ALPHA: dflt_reg       <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [8:0]                 dx_reg, dx_next;
    logic [8:0]                 dy_reg, dy_next;
    logic signed [10:0]         kx_reg, kx_next;
    logic signed [10:0]         ky_reg, ky_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [COORD_W-1:0]  x1_reg, x1_next;
    logic signed [COORD_W-1:0]  y1_reg, y1_next;
    logic [11:0]                fx_reg, fx_next;
    logic [11:0]                fy_reg, fy_next;
    logic [WGT_W-1:0]           w_reg [4];
    logic [WGT_W-1:0]           w_next [4];
    logic [ADDR_W-1:0]          row0_reg, row0_next;
    logic [ADDR_W-1:0]          row1_reg, row1_next;
    logic [TOT_W-1:0]           total_reg, total_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic                       outside_reg, outside_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    rsp_t                       rsp_reg, rsp_next;

    // Shared multiplier operands.
    logic signed [MUL_W-1:0]    mul_a, mul_b;

    // Other combinational nets.
    logic signed [ACC_W-1:0]    rot_sum;
    logic [8:0]                 ctr_size;
    logic signed [POS_W-1:0]    ctr_pos;
    logic signed [POS_W-1:0]    t_pos;
    logic signed [COORD_W-1:0]  split_int;
    logic [11:0]                split_frac;
    logic signed [COORD_W-1:0]  x1p, y1p;
    logic signed [COORD_W-1:0]  sw_s, sh_s;
    logic [1:0]                 xin, yin;
    logic                       outside_cond;
    logic [WGT_W-1:0]           wx0, wx1, wy0, wy1;
    logic [1:0]                 rd_tap, mac_tap;
    logic [7:0]                 tap_alpha;
    logic [SUM_W-1:0]           sum_acc;
    logic                       rsp_load;
    logic                       div_start;
    div_stat_t                  div_stat;
    logic [QUO_W-1:0]           div_quo;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [7:0]                 ram_rdata;

    // ------------------------------------------------------------------
    // Alpha store and divider.
    // ------------------------------------------------------------------
    // Store words write the RAM straight from the request while idle.
    assign ram_we = req_valid && (state_reg == ST_IDLE) && (req.mode == MODE_STORE);

    rba_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req.pixel_index[ADDR_W-1:0]),
        .wdata (req.alpha_in),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_acc),
        .divisor  (total_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // Coordinate split. The Q12 source position is the rotated sum scaled
    // down by 8 (the half-pixel destination offset carries a factor of 2 and the
    // Q2.14 angle a factor of 2^14) plus the source centre. Shifting out
    // half a pixel gives the left or top tap and its fraction. The same
    // adder serves the x axis and then the y axis.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == ST_XS)
        begin
            rot_sum  = acc_reg - prod_reg[ACC_W-1:0];
            ctr_size = src_width_reg;
        end
        else
        begin
            rot_sum  = acc_reg + prod_reg[ACC_W-1:0];
            ctr_size = src_height_reg;
        end
        ctr_pos    = $signed(POS_W'(rot_sum >>> 3)) + $signed({6'd0, ctr_size, 11'd0});
        t_pos      = ctr_pos - POS_W'(2048);
        split_int  = $signed(COORD_W'(t_pos >>> 12));
        split_frac = t_pos[11:0];
    end

    // Tap coverage of the source.
    assign x1p  = x1_reg + COORD_W'(1);
    assign y1p  = y1_reg + COORD_W'(1);
    assign sw_s = $signed({7'd0, src_width_reg});
    assign sh_s = $signed({7'd0, src_height_reg});

    assign xin[0] = !x1_reg[COORD_W-1] && (x1_reg < sw_s);
    assign xin[1] = !x1p[COORD_W-1] && (x1p < sw_s);
    assign yin[0] = !y1_reg[COORD_W-1] && (y1_reg < sh_s);
    assign yin[1] = !y1p[COORD_W-1] && (y1p < sh_s);

    // The window misses the source when both columns lie to one side or
    // both rows lie above or below.
    assign outside_cond = x1p[COORD_W-1] || (x1_reg >= sw_s) ||
                          y1p[COORD_W-1] || (y1_reg >= sh_s);

    // Per-axis weights: the near tap gets one minus the fraction, the far
    // tap the fraction itself.
    assign wx0 = ONE_Q12 - {1'b0, fx_reg};
    assign wx1 = {1'b0, fx_reg};
    assign wy0 = ONE_Q12 - {1'b0, fy_reg};
    assign wy1 = {1'b0, fy_reg};

    // Tap order: bit 0 selects the right column, bit 1 the lower row.
    always_comb
    begin
        unique case (state_reg)
            ST_RD1:  rd_tap = 2'd1;
            ST_RD2:  rd_tap = 2'd2;
            ST_RD3:  rd_tap = 2'd3;
            default: rd_tap = 2'd0;
        endcase
        unique case (state_reg)
            ST_RD2:  mac_tap = 2'd1;
            ST_RD3:  mac_tap = 2'd2;
            ST_MAC3: mac_tap = 2'd3;
            default: mac_tap = 2'd0;
        endcase
    end

    assign ram_raddr = (rd_tap[1] ? row1_reg : row0_reg) +
                       (rd_tap[0] ? x1p[ADDR_W-1:0] : x1_reg[ADDR_W-1:0]);

    // Taps that fall off the source read as the default alpha.
    assign tap_alpha = (xin[mac_tap[0]] && yin[mac_tap[1]]) ? ram_rdata : dflt_reg;

    assign sum_acc = sum_reg + prod_reg[SUM_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer. At most one product enters the multiplier each cycle and its
    // registered result is consumed in the following state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        kx_next      = kx_reg;
        ky_next      = ky_reg;
        acc_next     = acc_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        fx_next      = fx_reg;
        fy_next      = fy_reg;
        w_next       = w_reg;
        row0_next    = row0_reg;
        row1_next    = row1_reg;
        total_next   = total_reg;
        sum_next     = sum_reg;
        outside_next = outside_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        rsp_load     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && (req.mode == MODE_COMPUTE))
                begin
                    dx_next    = req.dst_x;
                    dy_next    = req.dst_y;
                    // Destination offset from the centre in half pixels.
                    kx_next    = $signed({1'b0, req.dst_x, 1'b1} - {1'b0, dst_width_reg});
                    ky_next    = $signed({1'b0, req.dst_y, 1'b1} - {1'b0, dst_height_reg});
                    state_next = ST_XC;
                end
            end
            ST_XC:
            begin
                mul_a      = MUL_W'(kx_reg);
                mul_b      = MUL_W'(cos_reg);
                state_next = ST_YS;
            end
            ST_YS:
            begin
                mul_a      = MUL_W'(ky_reg);
                mul_b      = MUL_W'(sin_reg);
                acc_next   = prod_reg[ACC_W-1:0];
                state_next = ST_XS;
            end
            ST_XS:
            begin
                mul_a      = MUL_W'(kx_reg);
                mul_b      = MUL_W'(sin_reg);
                x1_next    = split_int;
                fx_next    = split_frac;
                state_next = ST_YC;
            end
            ST_YC:
            begin
                mul_a      = MUL_W'(ky_reg);
                mul_b      = MUL_W'(cos_reg);
                acc_next   = prod_reg[ACC_W-1:0];
                state_next = ST_YEND;
            end
            ST_YEND:
            begin
                y1_next    = split_int;
                fy_next    = split_frac;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (outside_cond)
                begin
                    outside_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    outside_next = 1'b0;
                    mul_a        = $signed({4'd0, wx0});
                    mul_b        = $signed({4'd0, wy0});
                    state_next   = ST_W01;
                end
            end
            ST_W01:
            begin
                mul_a      = $signed({4'd0, wx1});
                mul_b      = $signed({4'd0, wy0});
                w_next[0]  = prod_reg[24:12];
                state_next = ST_W10;
            end
            ST_W10:
            begin
                mul_a      = $signed({4'd0, wx0});
                mul_b      = $signed({4'd0, wy1});
                w_next[1]  = prod_reg[24:12];
                state_next = ST_W11;
            end
            ST_W11:
            begin
                mul_a      = $signed({4'd0, wx1});
                mul_b      = $signed({4'd0, wy1});
                w_next[2]  = prod_reg[24:12];
                state_next = ST_ROW0;
            end
            ST_ROW0:
            begin
                mul_a      = MUL_W'(y1_reg);
                mul_b      = $signed({8'd0, src_width_reg});
                w_next[3]  = prod_reg[24:12];
                state_next = ST_ROW1;
            end
            ST_ROW1:
            begin
                mul_a      = MUL_W'(y1p);
                mul_b      = $signed({8'd0, src_width_reg});
                row0_next  = prod_reg[ADDR_W-1:0];
                total_next = TOT_W'(w_reg[0]) + TOT_W'(w_reg[1]) +
                             TOT_W'(w_reg[2]) + TOT_W'(w_reg[3]);
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                row1_next  = prod_reg[ADDR_W-1:0];
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                mul_a      = $signed({9'd0, tap_alpha});
                mul_b      = $signed({4'd0, w_reg[mac_tap]});
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                mul_a      = $signed({9'd0, tap_alpha});
                mul_b      = $signed({4'd0, w_reg[mac_tap]});
                sum_next   = prod_reg[SUM_W-1:0];
                state_next = ST_RD3;
            end
            ST_RD3:
            begin
                mul_a      = $signed({9'd0, tap_alpha});
                mul_b      = $signed({4'd0, w_reg[mac_tap]});
                sum_next   = sum_acc;
                state_next = ST_MAC3;
            end
            ST_MAC3:
            begin
                mul_a      = $signed({9'd0, tap_alpha});
                mul_b      = $signed({4'd0, w_reg[mac_tap]});
                sum_next   = sum_acc;
                state_next = ST_MAC4;
            end
            ST_MAC4:
            begin
                // The last product goes straight into the divider.
                sum_next   = sum_acc;
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result slot. The quotient never exceeds 255 because every alpha is
    // at most 255, so it fits the output byte as it stands.
    always_comb
    begin
        rsp_next.out_x     = dx_reg;
        rsp_next.out_y     = dy_reg;
        rsp_next.alpha_out = outside_reg ? dflt_reg : div_quo;
        rsp_next.outside   = outside_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_a * mul_b;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        kx_reg      <= kx_next;
        ky_reg      <= ky_next;
        acc_reg     <= acc_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        w_reg       <= w_next;
        row0_reg    <= row0_next;
        row1_reg    <= row1_next;
        total_reg   <= total_next;
        sum_reg     <= sum_next;
        outside_reg <= outside_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.mode == MODE_COMPUTE) |=> state_reg == ST_XC)
        else $error("compute word did not start the rotation sequence");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_outside_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) && outside_cond |=> (state_reg == ST_DONE) && !div_stat.busy)
        else $error("outside window did not go straight to the result");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD0 |-> total_reg <= TOT_MAX)
        else $error("weight total exceeds four full taps");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result word appeared without a finished computation");

endmodule
